/* rtl/core/rcai_pkg.sv */
// ----------------------------------------------------------------------------
// rcai_pkg
// Shared types, widths and the square root step of the ray and arc pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rcai_pkg;

	localparam int ROOT_W = 53;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 3;
	localparam int DISC_W = 104;
	localparam int FRONT_STAGES = 7;
	localparam int BACK_STAGES = 7;

	typedef enum logic [2:0] {
		REG_CENTRE_X     = 3'd0,
		REG_CENTRE_Y     = 3'd1,
		REG_RADIUS       = 3'd2,
		REG_ARC_COS      = 3'd3,
		REG_ARC_SIN      = 3'd4,
		REG_END_ROT_X    = 3'd5,
		REG_END_ROT_Y    = 3'd6,
		REG_MIN_DISTANCE = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] centre_x;
		logic signed [31:0] centre_y;
		logic        [30:0] radius;
		logic signed [17:0] arc_cos;
		logic signed [17:0] arc_sin;
		logic signed [31:0] end_rot_x;
		logic signed [31:0] end_rot_y;
		logic        [15:0] min_distance;
	} cfg_t;

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [17:0] vx;
		logic signed [17:0] vy;
		logic signed [51:0] g;
		logic               neg;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0]  rad;
	} sq_t;

	// One restoring square root step: brings in two radicand bits, yields one root bit.
	function automatic sq_t sqrt_step(sq_t a);
		sq_t o;
		logic [REM_W-1:0] r2;
		logic [REM_W-1:0] trial;
		r2 = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
		trial = {1'b0, a.root, 2'b01};
		if (r2 >= trial) begin
			o.rem = r2 - trial;
			o.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem = r2;
			o.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		o.rad = {a.rad[RAD_W-3:0], 2'b00};
		return o;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/rcai_front.sv */
// ----------------------------------------------------------------------------
// rcai_front
// Offsets, projection and discriminant of the ray against the circle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcai_front (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	input  wire signed [31:0]                origin_x,
	input  wire signed [31:0]                origin_y,
	input  wire signed [17:0]                dir_x,
	input  wire signed [17:0]                dir_y,
	input  rcai_pkg::cfg_t                   cfg,
	output logic                             out_valid,
	output logic [rcai_pkg::RAD_W-1:0]       out_rad,
	output rcai_pkg::side_t                  out_side
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [32:0] dx_s1, dy_s1;
	logic signed [17:0] vx_s1, vy_s1;

	logic signed [32:0] dx_s2, dy_s2;
	logic signed [17:0] vx_s2, vy_s2;
	logic signed [50:0] gx_s2, gy_s2;
	logic signed [65:0] dx2_s2, dy2_s2;
	logic        [61:0] r2_s2;

	rcai_pkg::side_t sd_s3, sd_s4, sd_s5, sd_s6, sd_s7;
	logic signed [66:0] c_s3, c_s4, c_s5, c_s6;
	logic        [50:0] gm_s4;
	logic        [63:0] ll_s5;
	logic        [50:0] hl_s5;
	logic        [37:0] hh_s5;
	logic       [101:0] g2_s6;
	logic [rcai_pkg::RAD_W-1:0] rad_s7;

	logic signed [50:0] gx_c, gy_c;
	logic signed [65:0] dx2_c, dy2_c;
	logic signed [66:0] c_c;
	logic signed [rcai_pkg::DISC_W-1:0] disc_c;

	assign gx_c = dx_s1 * vx_s1;
	assign gy_c = dy_s1 * vy_s1;
	assign dx2_c = dx_s1 * dx_s1;
	assign dy2_c = dy_s1 * dy_s1;
	assign c_c = $signed({5'd0, r2_s2}) - {dx2_s2[65], dx2_s2} - {dy2_s2[65], dy2_s2};
	assign disc_c = $signed({2'b00, g2_s6})
		+ $signed({{5{c_s6[66]}}, c_s6, 32'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= {origin_x[31], origin_x} - {cfg.centre_x[31], cfg.centre_x};
		dy_s1 <= {origin_y[31], origin_y} - {cfg.centre_y[31], cfg.centre_y};
		vx_s1 <= dir_x;
		vy_s1 <= dir_y;

		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
		vx_s2 <= vx_s1;
		vy_s2 <= vy_s1;
		gx_s2 <= gx_c;
		gy_s2 <= gy_c;
		dx2_s2 <= dx2_c;
		dy2_s2 <= dy2_c;
		r2_s2 <= 62'(cfg.radius) * 62'(cfg.radius);

		sd_s3.dx <= dx_s2;
		sd_s3.dy <= dy_s2;
		sd_s3.vx <= vx_s2;
		sd_s3.vy <= vy_s2;
		sd_s3.g <= {gx_s2[50], gx_s2} + {gy_s2[50], gy_s2};
		sd_s3.neg <= 1'b0;
		c_s3 <= c_c;

		sd_s4 <= sd_s3;
		c_s4 <= c_s3;
		gm_s4 <= sd_s3.g[51] ? 51'(-sd_s3.g) : sd_s3.g[50:0];

		sd_s5 <= sd_s4;
		c_s5 <= c_s4;
		ll_s5 <= 64'(gm_s4[31:0]) * 64'(gm_s4[31:0]);
		hl_s5 <= 51'(gm_s4[50:32]) * 51'(gm_s4[31:0]);
		hh_s5 <= 38'(gm_s4[50:32]) * 38'(gm_s4[50:32]);

		sd_s6 <= sd_s5;
		c_s6 <= c_s5;
		g2_s6 <= {hh_s5, 64'd0} + {18'd0, hl_s5, 33'd0} + {38'd0, ll_s5};

		sd_s7.dx <= sd_s6.dx;
		sd_s7.dy <= sd_s6.dy;
		sd_s7.vx <= sd_s6.vx;
		sd_s7.vy <= sd_s6.vy;
		sd_s7.g <= sd_s6.g;
		sd_s7.neg <= disc_c[rcai_pkg::DISC_W-1];
		rad_s7 <= disc_c[rcai_pkg::DISC_W-1] ? '0
			: {2'b00, disc_c};
	end

	assign out_valid = v_s7;
	assign out_rad = rad_s7;
	assign out_side = sd_s7;

endmodule

`default_nettype wire

/* rtl/core/rcai_sqrt.sv */
// ----------------------------------------------------------------------------
// rcai_sqrt
// Pipelined floor square root, one root bit per stage, with side data.
// ----------------------------------------------------------------------------
`default_nettype none

module rcai_sqrt (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	input  wire [rcai_pkg::RAD_W-1:0]        in_rad,
	input  rcai_pkg::side_t                  in_side,
	output logic                             out_valid,
	output logic [rcai_pkg::ROOT_W-1:0]      out_root,
	output rcai_pkg::side_t                  out_side
);

	localparam int N = rcai_pkg::ROOT_W;

	logic            val_sn [N];
	rcai_pkg::sq_t   sq_sn  [N];
	rcai_pkg::side_t sd_sn  [N];
	rcai_pkg::sq_t   seed;

	assign seed.rem = '0;
	assign seed.root = '0;
	assign seed.rad = in_rad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				val_sn[i] <= 1'b0;
			end
		end else begin
			val_sn[0] <= in_valid;
			for (int i = 1; i < N; i++) begin
				val_sn[i] <= val_sn[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_sn[0] <= rcai_pkg::sqrt_step(seed);
		sd_sn[0] <= in_side;
		for (int i = 1; i < N; i++) begin
			sq_sn[i] <= rcai_pkg::sqrt_step(sq_sn[i-1]);
			sd_sn[i] <= sd_sn[i-1];
		end
	end

	assign out_valid = val_sn[N-1];
	assign out_root = sq_sn[N-1].root;
	assign out_side = sd_sn[N-1];

endmodule

`default_nettype wire

/* rtl/core/rcai_back.sv */
// ----------------------------------------------------------------------------
// rcai_back
// Roots, hit points, arc test and choice of the nearest valid hit.
// ----------------------------------------------------------------------------
`default_nettype none

module rcai_back (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	input  wire [rcai_pkg::ROOT_W-1:0]       in_root,
	input  rcai_pkg::side_t                  in_side,
	input  rcai_pkg::cfg_t                   cfg,
	output logic                             done,
	output logic                             hit,
	output logic [30:0]                      distance
);

	function automatic logic on_arc(logic signed [60:0] rx, logic signed [60:0] ry,
			logic signed [60:0] ex, logic ey_neg);
		logic r;
		if (!ey_neg) begin
			r = !ry[60] && (ex <= rx);
		end else begin
			r = !ry[60] || (rx <= ex);
		end
		return r;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [32:0] dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [17:0] vx_s1, vy_s1, vx_s2, vy_s2;
	logic               neg_s1;
	logic signed [53:0] t0_s1, t1_s1;

	logic ok0_s2, ok1_s2, ok0_s3, ok1_s3, ok0_s4, ok1_s4;
	logic ok0_s5, ok1_s5, ok0_s6, ok1_s6;
	logic lt_s2, lt_s3, lt_s4, lt_s5, lt_s6;
	logic [37:0] u0_s2, u1_s2, u0_s3, u1_s3, u0_s4, u1_s4, u0_s5, u1_s5, u0_s6, u1_s6;

	logic signed [56:0] mx0_s3, my0_s3, mx1_s3, my1_s3;
	logic signed [41:0] px0_s4, py0_s4, px1_s4, py1_s4;
	logic signed [59:0] a0_s5, b0_s5, c0_s5, d0_s5, a1_s5, b1_s5, c1_s5, d1_s5;
	logic signed [60:0] rx0_s6, ry0_s6, rx1_s6, ry1_s6;

	logic        done_s7, hit_s7;
	logic [30:0] dist_s7;

	logic signed [53:0] ge, se, eps;
	logic signed [60:0] ex;
	logic f0, f1, any;
	logic [37:0] usel;

	assign ge = {{2{in_side.g[51]}}, in_side.g};
	assign se = $signed({1'b0, in_root});
	assign eps = $signed({22'd0, cfg.min_distance, 16'd0});
	assign ex = $signed({{13{cfg.end_rot_x[31]}}, cfg.end_rot_x, 16'd0});

	assign f0 = ok0_s6 && on_arc(rx0_s6, ry0_s6, ex, cfg.end_rot_y[31]);
	assign f1 = ok1_s6 && on_arc(rx1_s6, ry1_s6, ex, cfg.end_rot_y[31]) && (!f0 || lt_s6);
	assign any = f0 || f1;
	assign usel = f1 ? u1_s6 : u0_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			done_s7 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			done_s7 <= v_s6;
		end
	end

	assign v_s7 = done_s7;

	always_ff @(posedge clk) begin
		t0_s1 <= se - ge;
		t1_s1 <= -ge - se;
		dx_s1 <= in_side.dx;
		dy_s1 <= in_side.dy;
		vx_s1 <= in_side.vx;
		vy_s1 <= in_side.vy;
		neg_s1 <= in_side.neg;

		ok0_s2 <= !neg_s1 && (t0_s1 > eps);
		ok1_s2 <= !neg_s1 && (t1_s1 > eps);
		lt_s2 <= t1_s1 < t0_s1;
		u0_s2 <= t0_s1[53:16];
		u1_s2 <= t1_s1[53:16];
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
		vx_s2 <= vx_s1;
		vy_s2 <= vy_s1;

		mx0_s3 <= vx_s2 * $signed({1'b0, u0_s2});
		my0_s3 <= vy_s2 * $signed({1'b0, u0_s2});
		mx1_s3 <= vx_s2 * $signed({1'b0, u1_s2});
		my1_s3 <= vy_s2 * $signed({1'b0, u1_s2});
		dx_s3 <= dx_s2;
		dy_s3 <= dy_s2;
		ok0_s3 <= ok0_s2;
		ok1_s3 <= ok1_s2;
		lt_s3 <= lt_s2;
		u0_s3 <= u0_s2;
		u1_s3 <= u1_s2;

		px0_s4 <= {{9{dx_s3[32]}}, dx_s3} + {mx0_s3[56], mx0_s3[56:16]};
		py0_s4 <= {{9{dy_s3[32]}}, dy_s3} + {my0_s3[56], my0_s3[56:16]};
		px1_s4 <= {{9{dx_s3[32]}}, dx_s3} + {mx1_s3[56], mx1_s3[56:16]};
		py1_s4 <= {{9{dy_s3[32]}}, dy_s3} + {my1_s3[56], my1_s3[56:16]};
		ok0_s4 <= ok0_s3;
		ok1_s4 <= ok1_s3;
		lt_s4 <= lt_s3;
		u0_s4 <= u0_s3;
		u1_s4 <= u1_s3;

		a0_s5 <= cfg.arc_cos * px0_s4;
		b0_s5 <= cfg.arc_sin * py0_s4;
		c0_s5 <= cfg.arc_cos * py0_s4;
		d0_s5 <= cfg.arc_sin * px0_s4;
		a1_s5 <= cfg.arc_cos * px1_s4;
		b1_s5 <= cfg.arc_sin * py1_s4;
		c1_s5 <= cfg.arc_cos * py1_s4;
		d1_s5 <= cfg.arc_sin * px1_s4;
		ok0_s5 <= ok0_s4;
		ok1_s5 <= ok1_s4;
		lt_s5 <= lt_s4;
		u0_s5 <= u0_s4;
		u1_s5 <= u1_s4;

		rx0_s6 <= {a0_s5[59], a0_s5} + {b0_s5[59], b0_s5};
		ry0_s6 <= {c0_s5[59], c0_s5} - {d0_s5[59], d0_s5};
		rx1_s6 <= {a1_s5[59], a1_s5} + {b1_s5[59], b1_s5};
		ry1_s6 <= {c1_s5[59], c1_s5} - {d1_s5[59], d1_s5};
		ok0_s6 <= ok0_s5;
		ok1_s6 <= ok1_s5;
		lt_s6 <= lt_s5;
		u0_s6 <= u0_s5;
		u1_s6 <= u1_s5;

		hit_s7 <= any;
		if (!any) begin
			dist_s7 <= '0;
		end else if (|usel[37:31]) begin
			dist_s7 <= 31'h7fffffff;
		end else begin
			dist_s7 <= usel[30:0];
		end
	end

	assign done = v_s7;
	assign hit = hit_s7;
	assign distance = dist_s7;

endmodule

`default_nettype wire

/* rtl/core/ray_circle_arc_intersect_unit.sv */
// ----------------------------------------------------------------------------
// ray_circle_arc_intersect_unit
// Intersects 2D rays with a configured circular arc and reports the nearest hit.
// ----------------------------------------------------------------------------
// The unit takes one ray in every clock cycle and never raises busy. Each
// result appears on done, hit and distance for one cycle; most of the
// pipeline is the 53-stage square root of the discriminant, one root bit
// per stage, between the front and back ends. Results come out in ray order.
// Configuration writes are always ready and must only be made while no ray is
// in flight.
`default_nettype none

module ray_circle_arc_intersect_unit (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire signed [31:0] origin_x,
	input  wire signed [31:0] origin_y,
	input  wire signed [17:0] dir_x,
	input  wire signed [17:0] dir_y,
	output logic              done,
	output logic              hit,
	output logic [30:0]       distance,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire [2:0]         cfg_index,
	input  wire [31:0]        cfg_data
);

	rcai_pkg::cfg_t  cfg_q;
	logic            fr_valid, sq_valid;
	logic [rcai_pkg::RAD_W-1:0]  fr_rad;
	logic [rcai_pkg::ROOT_W-1:0] sq_root;
	rcai_pkg::side_t fr_side, sq_side;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre_x <= '0;
			cfg_q.centre_y <= '0;
			cfg_q.radius <= 31'd65536;
			cfg_q.arc_cos <= 18'sd65536;
			cfg_q.arc_sin <= '0;
			cfg_q.end_rot_x <= 32'sd65536;
			cfg_q.end_rot_y <= '0;
			cfg_q.min_distance <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (rcai_pkg::reg_idx_t'(cfg_index))
				rcai_pkg::REG_CENTRE_X: cfg_q.centre_x <= cfg_data;
				rcai_pkg::REG_CENTRE_Y: cfg_q.centre_y <= cfg_data;
				rcai_pkg::REG_RADIUS: cfg_q.radius <= cfg_data[30:0];
				rcai_pkg::REG_ARC_COS: cfg_q.arc_cos <= cfg_data[17:0];
				rcai_pkg::REG_ARC_SIN: cfg_q.arc_sin <= cfg_data[17:0];
				rcai_pkg::REG_END_ROT_X: cfg_q.end_rot_x <= cfg_data;
				rcai_pkg::REG_END_ROT_Y: cfg_q.end_rot_y <= cfg_data;
				rcai_pkg::REG_MIN_DISTANCE: cfg_q.min_distance <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	rcai_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.cfg       (cfg_q),
		.out_valid (fr_valid),
		.out_rad   (fr_rad),
		.out_side  (fr_side)
	);

	rcai_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_rad    (fr_rad),
		.in_side   (fr_side),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	rcai_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq_valid),
		.in_root  (sq_root),
		.in_side  (sq_side),
		.cfg      (cfg_q),
		.done     (done),
		.hit      (hit),
		.distance (distance)
	);

	a_front_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(rcai_pkg::FRONT_STAGES) fr_valid)
		else $error("word lost in front end");

	// A word leaving the front end reaches the back end after every root stage.
	a_sqrt_latency: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid |-> ##(rcai_pkg::ROOT_W) sq_valid)
		else $error("word lost in square root pipeline");

	a_back_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid |-> ##(rcai_pkg::BACK_STAGES) done)
		else $error("word lost in back end");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(sq_valid, rcai_pkg::BACK_STAGES))
		else $error("result strobe without a word in flight");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> distance == 31'd0)
		else $error("miss reported with nonzero distance");

endmodule

`default_nettype wire

/* tb/ray_circle_arc_intersect_unit_checker.sv */
// ----------------------------------------------------------------------------
// ray_circle_arc_intersect_unit_checker
// Watches the ray, result and register channels of the arc intersect unit.
// It keeps its own copy of the registers, works out the hit flag and the
// distance for every accepted ray, and compares each result word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_circle_arc_intersect_unit_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire               busy,
	input  wire signed [31:0] origin_x,
	input  wire signed [31:0] origin_y,
	input  wire signed [17:0] dir_x,
	input  wire signed [17:0] dir_y,
	input  wire               done,
	input  wire               hit,
	input  wire [30:0]        distance,
	input  wire               cfg_valid,
	input  wire               cfg_ready,
	input  wire [2:0]         cfg_index,
	input  wire [31:0]        cfg_data,
	output int                errors,
	output int                pending,
	output int                hits_seen
);

	typedef struct packed {
		logic        hit;
		logic [30:0] distance;
	} hit_word_t;

	rcai_pkg::cfg_t arc_cfg;
	hit_word_t      hit_queue[$];

	function automatic logic point_on_arc(longint px, longint py);
		longint rx;
		longint ry;
		longint ex;
		rx = longint'(arc_cfg.arc_cos) * px + longint'(arc_cfg.arc_sin) * py;
		ry = longint'(arc_cfg.arc_cos) * py - longint'(arc_cfg.arc_sin) * px;
		ex = longint'(arc_cfg.end_rot_x) * 65536;
		if (arc_cfg.end_rot_y >= 0)
			return ry >= 0 && ex <= rx;
		if (ry >= 0)
			return 1'b1;
		return rx <= ex;
	endfunction

	function automatic hit_word_t nearest_hit(logic signed [31:0] ox, logic signed [31:0] oy,
			logic signed [17:0] vx_in, logic signed [17:0] vy_in);
		hit_word_t w;
		longint dx;
		longint dy;
		longint vx;
		longint vy;
		longint g;
		longint eps;
		longint t;
		longint best;
		longint t16;
		longint px;
		longint py;
		logic signed [127:0] disc;
		logic [127:0] sq;
		logic [63:0] s;
		logic [63:0] trial;
		logic found;
		dx = longint'(ox) - longint'(arc_cfg.centre_x);
		dy = longint'(oy) - longint'(arc_cfg.centre_y);
		vx = longint'(vx_in);
		vy = longint'(vy_in);
		g = dx * vx + dy * vy;
		eps = longint'(arc_cfg.min_distance) * 65536;
		w = '0;
		best = 0;
		found = 1'b0;
		disc = 128'(arc_cfg.radius) * 128'(arc_cfg.radius);
		disc = disc - 128'(dx) * 128'(dx) - 128'(dy) * 128'(dy);
		disc = (disc <<< 32) + 128'(g) * 128'(g);
		if (disc[127])
			return w;
		s = 0;
		for (int b = 52; b >= 0; b--) begin
			trial = s | (64'd1 << b);
			sq = 128'(trial) * 128'(trial);
			if (sq <= 128'(disc))
				s = trial;
		end
		for (int i = 0; i < 2; i++) begin
			t = (i == 0) ? -g + longint'(s) : -g - longint'(s);
			if (t > eps && (!found || t < best)) begin
				t16 = longint'(64'(t) >> 16);
				px = dx + ((vx * t16) >>> 16);
				py = dy + ((vy * t16) >>> 16);
				if (point_on_arc(px, py)) begin
					found = 1'b1;
					best = t;
				end
			end
		end
		if (found) begin
			t16 = longint'(64'(best) >> 16);
			if (t16 > 64'sd2147483647)
				t16 = 64'sd2147483647;
			w.hit = 1'b1;
			w.distance = t16[30:0];
		end
		return w;
	endfunction

	assign pending = hit_queue.size();

	always @(posedge clk or negedge arst_n) begin
		hit_word_t want;
		if (!arst_n) begin
			arc_cfg.centre_x <= 0;
			arc_cfg.centre_y <= 0;
			arc_cfg.radius <= 31'd65536;
			arc_cfg.arc_cos <= 18'sd65536;
			arc_cfg.arc_sin <= 0;
			arc_cfg.end_rot_x <= 32'sd65536;
			arc_cfg.end_rot_y <= 0;
			arc_cfg.min_distance <= 16'd1;
			errors <= 0;
			hits_seen <= 0;
			hit_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (rcai_pkg::reg_idx_t'(cfg_index))
					rcai_pkg::REG_CENTRE_X:     arc_cfg.centre_x <= cfg_data;
					rcai_pkg::REG_CENTRE_Y:     arc_cfg.centre_y <= cfg_data;
					rcai_pkg::REG_RADIUS:       arc_cfg.radius <= cfg_data[30:0];
					rcai_pkg::REG_ARC_COS:      arc_cfg.arc_cos <= cfg_data[17:0];
					rcai_pkg::REG_ARC_SIN:      arc_cfg.arc_sin <= cfg_data[17:0];
					rcai_pkg::REG_END_ROT_X:    arc_cfg.end_rot_x <= cfg_data;
					rcai_pkg::REG_END_ROT_Y:    arc_cfg.end_rot_y <= cfg_data;
					rcai_pkg::REG_MIN_DISTANCE: arc_cfg.min_distance <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (done) begin
				if (hit_queue.size() == 0) begin
					$error("result word with no ray waiting: hit %0d distance %0d",
						hit, distance);
					errors <= errors + 1;
				end else begin
					want = hit_queue.pop_front();
					if (hit)
						hits_seen <= hits_seen + 1;
					if (want.hit !== hit) begin
						$error("hit: expected %0d, actual %0d", want.hit, hit);
						errors <= errors + 1;
					end else if (want.distance !== distance) begin
						$error("distance: expected %0d, actual %0d", want.distance, distance);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy)
				hit_queue.push_back(nearest_hit(origin_x, origin_y, dir_x, dir_y));
		end
	end

endmodule

`default_nettype wire

/* tb/ray_circle_arc_intersect_unit_test.sv */
// ----------------------------------------------------------------------------
// ray_circle_arc_intersect_unit_test
// Drives rays and register writes into the arc intersect unit.
// A directed set of edge rays comes first, then phases of random rays under
// several arc settings and idle patterns; the checker judges every result.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_circle_arc_intersect_unit_test;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [31:0] origin_x = 0;
	logic signed [31:0] origin_y = 0;
	logic signed [17:0] dir_x = 0;
	logic signed [17:0] dir_y = 0;
	logic               cfg_valid = 1'b0;
	logic [2:0]         cfg_index = 0;
	logic [31:0]        cfg_data = 0;
	wire                busy;
	wire                done;
	wire                hit;
	wire [30:0]         distance;
	wire                cfg_ready;
	int                 errors;
	int                 pending;
	int                 hits_seen;
	int                 cycles = 0;
	int                 rays_sent = 0;
	int                 idle_pct = 0;
	longint             cur_cx = 0;
	longint             cur_cy = 0;
	longint             cur_r = 65536;

	always #4 clk = ~clk;

	ray_circle_arc_intersect_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.origin_x(origin_x), .origin_y(origin_y), .dir_x(dir_x), .dir_y(dir_y),
		.done(done), .hit(hit), .distance(distance),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ray_circle_arc_intersect_unit_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.origin_x(origin_x), .origin_y(origin_y), .dir_x(dir_x), .dir_y(dir_y),
		.done(done), .hit(hit), .distance(distance),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .hits_seen(hits_seen)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [17:0] vx, logic [17:0] vy);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		origin_x <= ox;
		origin_y <= oy;
		dir_x <= vx;
		dir_y <= vy;
		do @(posedge clk); while (busy);
		rays_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Leaves valid high; the caller drops it after the last word.
	task automatic write_reg(rcai_pkg::reg_idx_t idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_arc(longint cx, longint cy, longint r, real a0, real span, int eps);
		write_reg(rcai_pkg::REG_CENTRE_X, 32'(cx));
		write_reg(rcai_pkg::REG_CENTRE_Y, 32'(cy));
		write_reg(rcai_pkg::REG_RADIUS, 32'(r));
		write_reg(rcai_pkg::REG_ARC_COS, 32'($rtoi($cos(a0) * 65536.0)));
		write_reg(rcai_pkg::REG_ARC_SIN, 32'($rtoi($sin(a0) * 65536.0)));
		write_reg(rcai_pkg::REG_END_ROT_X, 32'($rtoi($cos(span) * r)));
		write_reg(rcai_pkg::REG_END_ROT_Y, 32'($rtoi($sin(span) * r)));
		write_reg(rcai_pkg::REG_MIN_DISTANCE, 32'(eps));
		cfg_valid <= 1'b0;
		cur_cx = cx;
		cur_cy = cy;
		cur_r = r;
	endtask

	task automatic random_ray();
		real    a;
		longint ox;
		longint oy;
		if ($urandom_range(99) < 25) begin
			send_ray($urandom, $urandom, 18'($urandom), 18'($urandom));
		end else begin
			a = $urandom_range(62831) / 10000.0;
			ox = cur_cx + $signed($urandom_range(6000) - 3000) * (cur_r / 1000 + 1);
			oy = cur_cy + $signed($urandom_range(6000) - 3000) * (cur_r / 1000 + 1);
			send_ray(32'(ox), 32'(oy), 18'($rtoi($cos(a) * 65536.0)),
				18'($rtoi($sin(a) * 65536.0)));
		end
	endtask

	initial begin
		int  idles[4];
		real a0;
		idles = '{0, 46, 0, 36};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edge rays under the reset arc: a unit circle with a zero-length arc.
		send_ray(32'h7fffffff, 32'h80000000, 18'sd65536, -18'sd65536);
		send_ray(32'h80000000, 32'h7fffffff, -18'sd65536, 18'sd65536);
		send_ray(0, 0, 18'sd65536, 0);
		send_ray(0, 0, 0, 0);
		send_ray(-32'sd131072, 0, 18'sd65536, 0);
		send_ray(-32'sd131072, 32'sd65536, 18'sd65536, 0);
		send_ray(-32'sd131072, 32'sd70000, 18'sd65536, 0);
		send_ray(0, 0, 18'h20000, 18'h1ffff);
		send_ray(0, 0, 18'h3ffff, 18'h3ffff);
		drain();
		set_arc(0, 0, 65536, 0.0, 3.0, 0);
		send_ray(0, -32'sd131072, 0, 18'sd65536);
		send_ray(0, 0, 0, 18'sd65536);
		send_ray(0, 0, 0, -18'sd65536);
		send_ray(32'sd65536, 0, -18'sd65536, 0);
		drain();
		// Largest circle: the distance saturates.
		set_arc(0, 0, 31'h7fffffff, 3.14159, 6.0, 16'hffff);
		send_ray(32'h80000000, 0, 18'sd65536, 0);
		send_ray(32'h7fffffff, 32'h7fffffff, -18'sd46341, -18'sd46341);
		send_ray(0, 0, 18'sd65536, 0);
		send_ray(0, 0, -18'sd65536, 0);
		drain();
		set_arc(32'sh7fffffff, 32'sh80000000, 0, -1.5, 1.0, 0);
		send_ray(32'h7fffffff, 32'h80000000, 18'sd65536, 0);
		send_ray(0, 0, 18'sd65536, -18'sd65536);
		drain();

		for (int ph = 0; ph < 16; ph++) begin
			a0 = $urandom_range(62831) / 10000.0;
			set_arc($signed($urandom_range(2000000) - 1000000) * 64,
				$signed($urandom_range(2000000) - 1000000) * 64,
				(ph % 5 == 4) ? longint'($urandom_range(32'h7fffffff)) :
					longint'($urandom_range(1 << 23, 1)),
				a0, $urandom_range(62831) / 10000.0,
				(ph % 4 == 3) ? 16'hffff : $urandom_range(300));
			idle_pct = idles[ph % 4];
			repeat (50) random_ray();
			drain();
		end
		idle_pct = 0;

		$display("Sent %0d rays over 20 arc settings with random gaps; %0d came back as hits.",
			rays_sent, hits_seen);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
